FILE: design/assa_pkg.sv
// shared types and constants for the annealed secant step ascent core
// no dependencies; compiled first
package assa_pkg;

	// operation codes of an input item
	localparam int OP_W = 2;
	typedef enum logic [OP_W-1:0] {
		OP_SEED_PREV = 2'd0,
		OP_SEED_CURR = 2'd1,
		OP_EVAL      = 2'd2
	} op_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DERIV_TOL    = 3'd0,
		REG_TEMP_FLOOR   = 3'd1,
		REG_TEMP_FACTOR  = 3'd2,
		REG_TARGET_MAX   = 3'd3,
		REG_MAX_MARGIN   = 3'd4,
		REG_ITER_LIMIT   = 3'd5,
		REG_STEP_LIMIT   = 3'd6
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAT,
		ST_SETUP,
		ST_MUL1,
		ST_DIV,
		ST_MUL2,
		ST_CLAMP,
		ST_FINISH
	} state_t;

	// products saturate to 64 bits; the shared adder has two guard bits
	localparam int PROD_W = 64;
	localparam int ADD_W  = PROD_W + 2;
	// iteration counter holds up to PROD_W
	localparam int ITER_W = $clog2(PROD_W + 1);

	// signed 64-bit bounds in adder width
	localparam logic signed [ADD_W-1:0] INT64_HI = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ADD_W-1:0] INT64_LO = 66'sh3_8000_0000_0000_0000;

endpackage

FILE: design/assa_if.sv
// channel interfaces of the annealed secant step ascent core
// request, response and configuration write channels; uses assa_pkg

interface assa_req_if #(parameter int VALUE_WIDTH = 32);
	import assa_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [OP_W-1:0]               operation;
	logic signed [VALUE_WIDTH-1:0] point_x;
	logic signed [VALUE_WIDTH-1:0] objective_value;
	logic signed [VALUE_WIDTH-1:0] objective_slope;
	modport source (output valid, operation, point_x, objective_value, objective_slope,
		input ready);
	modport sink (input valid, operation, point_x, objective_value, objective_slope,
		output ready);
endinterface

interface assa_rsp_if #(parameter int VALUE_WIDTH = 32, parameter int COUNT_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] proposed_x;
	logic                          keep_going;
	logic signed [VALUE_WIDTH-1:0] best_x;
	logic signed [VALUE_WIDTH-1:0] best_value;
	logic [COUNT_WIDTH-1:0]        steps_taken;
	modport source (output valid, proposed_x, keep_going, best_x, best_value, steps_taken,
		input ready);
	modport sink (input valid, proposed_x, keep_going, best_x, best_value, steps_taken,
		output ready);
endinterface

interface assa_cfg_if #(parameter int VALUE_WIDTH = 32);
	import assa_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [VALUE_WIDTH-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/annealed_secant_step_ascent_core.sv
// top level of the annealed secant step ascent core
// sequencer plus one shared shift-add/subtract unit; uses assa_pkg and assa_if
//
// Usage: the host seeds the previous point (operation 0), then the current point
// (operation 1), and afterwards returns value and slope at each proposed x
// (operation 2). Every operation 1 or 2 item yields one response item carrying the
// next x to evaluate, the keep-going flag, the accepted x, its value and the step
// count; operation 0 and the unused code yield nothing. Registers are written over
// cfg, which is always ready; the user must write them only while the core is idle,
// and the core does not enforce it. One shared adder does every product and the
// quotient a bit per cycle. An item with a nonzero slope difference runs heat*|dx|,
// the division by |ddx| and the product with |slope|, preceded by a temperature
// product whenever the slope changes sign. Equal slopes skip the arithmetic.
// req.ready is high only when idle, so the core takes no new item before it has
// finished the arithmetic of the last one.
// Stall: the result sits in an output register; the core accepts the next item
// while it waits, and only holds its final state if a second result is due.
// Reset: registers take their defaults, heat is 1.0, all points and count are zero.
module annealed_secant_step_ascent_core #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	assa_req_if.sink      req,
	assa_rsp_if.source    rsp,
	assa_cfg_if.sink      cfg
);
	import assa_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int F     = FRACTION_BITS;
	localparam int HW    = FRACTION_BITS + 1;
	localparam int DIV_N = (W + HW > PROD_W) ? PROD_W : W + HW;
	localparam logic [HW-1:0] HEAT_ONE = HW'(1) << F;
	localparam logic [HW-1:0] HEAT_MAX = '1;

	// configuration registers
	logic [W-2:0]              deriv_tolerance_q;
	logic [HW-1:0]             temperature_floor_q;
	logic [HW-1:0]             temperature_factor_q;
	logic signed [W-1:0]       target_maximum_q;
	logic signed [W-1:0]       maximum_margin_q;
	logic [COUNT_WIDTH-1:0]    iteration_limit_q;
	logic [W-2:0]              step_limit_q;

	// search state
	logic signed [W-1:0]       here_x_q, before_x_q, here_slope_q, before_slope_q;
	logic signed [W-1:0]       here_value_q, pending_x_q;
	logic [HW-1:0]             heat_q;
	logic [COUNT_WIDTH-1:0]    step_count_q;

	// sequencer and shared unit
	state_t                    state_q, state_d;
	logic [ITER_W-1:0]         cnt_q;
	logic [PROD_W-1:0]         acc_q, sh_q, addend_q;
	logic [W-1:0]              rem_q;
	logic                      sat_q, flat_q;
	logic [W-2:0]              mag_q;

	// output register
	logic                      out_valid_q;
	logic signed [W-1:0]       out_prop_q, out_best_x_q, out_best_value_q;
	logic                      out_keep_q;
	logic [COUNT_WIDTH-1:0]    out_steps_q;

	// handshake and control
	logic req_take, rsp_free, out_load, last_iter, slope_flip;

	// shared adder
	logic [ADD_W-1:0] add_x, add_y, add_sum;
	logic             add_sub;
	logic [W:0]       div_part;
	logic             div_ge, mul_ovf;
	logic [PROD_W-1:0] acc_next, prod1, quot, m_raw, m_sh, h_sh;

	// operand differences and magnitudes
	logic signed [W:0] dx_diff, ddx_diff;
	logic [W-1:0]      dx_mag, ddx_mag, slope_mag;

	// final sum and keep-going tests
	logic              off_neg;
	logic signed [W:0] off_ext, prop_sum;
	logic signed [W-1:0] prop_x;
	logic signed [ADD_W-1:0] max_diff, max_diff_c;
	logic              slope_ok, heat_ok, max_ok, count_ok;

	// differences for the secant ratio
	always_comb begin
		dx_diff   = (W+1)'(here_x_q) - (W+1)'(before_x_q);
		ddx_diff  = (W+1)'(here_slope_q) - (W+1)'(before_slope_q);
		dx_mag    = dx_diff[W] ? W'(-dx_diff) : dx_diff[W-1:0];
		ddx_mag   = ddx_diff[W] ? W'(-ddx_diff) : ddx_diff[W-1:0];
		slope_mag = here_slope_q[W-1] ? W'(-here_slope_q) : here_slope_q;
	end

	// sign change between the stored slope and the incoming one
	assign slope_flip = (here_slope_q[W-1] != req.objective_slope[W-1]) ||
		((here_slope_q == '0) != (req.objective_slope == '0));

	// shared shift-add / shift-subtract unit
	always_comb begin
		add_x    = '0;
		add_y    = '0;
		add_sub  = 1'b0;
		div_part = {rem_q, sh_q[PROD_W-1]};
		case (state_q) inside
			ST_HEAT, ST_MUL1, ST_MUL2: begin
				add_x = {1'b0, acc_q, 1'b0};
				add_y = sh_q[PROD_W-1] ? {2'b00, addend_q} : '0;
			end
			ST_DIV: begin
				add_x   = ADD_W'(div_part);
				add_y   = ADD_W'(addend_q[W-1:0]);
				add_sub = 1'b1;
			end
			default: ;
		endcase
		add_sum  = add_x + (add_sub ? ~add_y : add_y) + ADD_W'(add_sub);
		div_ge   = !add_sum[ADD_W-1];
		mul_ovf  = |add_sum[ADD_W-1:PROD_W];
		acc_next = add_sum[PROD_W-1:0];
		prod1    = (sat_q || mul_ovf) ? '1 : acc_next;
		quot     = {acc_q[PROD_W-2:0], div_ge};
		h_sh     = acc_next >> F;
		m_raw    = sat_q ? '1 : acc_q;
		m_sh     = m_raw >> F;
	end

	// proposed x: add the signed offset and clamp to the value range
	always_comb begin
		off_neg  = here_slope_q[W-1] && !flat_q;
		off_ext  = off_neg ? -(W+1)'(mag_q) : (W+1)'(mag_q);
		prop_sum = (W+1)'(here_x_q) + off_ext;
		if (prop_sum[W] != prop_sum[W-1]) begin
			prop_x = prop_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			prop_x = prop_sum[W-1:0];
		end
	end

	// continuation tests
	always_comb begin
		max_diff = ADD_W'(target_maximum_q) - ADD_W'(here_value_q);
		if (max_diff > INT64_HI) begin
			max_diff_c = INT64_HI;
		end else if (max_diff < INT64_LO) begin
			max_diff_c = INT64_LO;
		end else begin
			max_diff_c = max_diff;
		end
		slope_ok = slope_mag > W'(deriv_tolerance_q);
		heat_ok  = heat_q > temperature_floor_q;
		max_ok   = (target_maximum_q == maximum_margin_q) ||
			(max_diff_c > ADD_W'(maximum_margin_q));
		count_ok = step_count_q < iteration_limit_q;
	end

	// handshake outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		req_take  = req.valid && req.ready;
		rsp_free  = !out_valid_q || rsp.ready;
		out_load  = (state_q == ST_FINISH) && rsp_free;
		last_iter = (cnt_q == '0);
		cfg.ready = 1'b1;
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.proposed_x  = out_prop_q;
	assign rsp.keep_going  = out_keep_q;
	assign rsp.best_x      = out_best_x_q;
	assign rsp.best_value  = out_best_value_q;
	assign rsp.steps_taken = out_steps_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					unique case (req.operation)
						OP_SEED_CURR: state_d = ST_SETUP;
						OP_EVAL:      state_d = slope_flip ? ST_HEAT : ST_SETUP;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_HEAT:   if (last_iter) state_d = ST_SETUP;
			ST_SETUP:  state_d = (here_slope_q == before_slope_q) ? ST_CLAMP : ST_MUL1;
			ST_MUL1:   if (last_iter) state_d = ST_DIV;
			ST_DIV:    if (last_iter) state_d = ST_MUL2;
			ST_MUL2:   if (last_iter) state_d = ST_CLAMP;
			ST_CLAMP:  state_d = ST_FINISH;
			ST_FINISH: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deriv_tolerance_q    <= (W-1)'(655);
			temperature_floor_q  <= HW'(655);
			temperature_factor_q <= HEAT_ONE >> 1;
			target_maximum_q     <= '0;
			maximum_margin_q     <= '0;
			iteration_limit_q    <= COUNT_WIDTH'(100);
			step_limit_q         <= (W-1)'(HEAT_ONE);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DERIV_TOL:   deriv_tolerance_q    <= cfg.data[W-2:0];
				REG_TEMP_FLOOR:  temperature_floor_q  <= cfg.data[HW-1:0];
				REG_TEMP_FACTOR: temperature_factor_q <= cfg.data[HW-1:0];
				REG_TARGET_MAX:  target_maximum_q     <= cfg.data;
				REG_MAX_MARGIN:  maximum_margin_q     <= cfg.data;
				REG_ITER_LIMIT:  iteration_limit_q    <= cfg.data[COUNT_WIDTH-1:0];
				REG_STEP_LIMIT:  step_limit_q         <= cfg.data[W-2:0];
				default: ;
			endcase
		end
	end

	// search state, shared unit sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			here_x_q         <= '0;
			before_x_q       <= '0;
			here_slope_q     <= '0;
			before_slope_q   <= '0;
			here_value_q     <= '0;
			pending_x_q      <= '0;
			heat_q           <= HEAT_ONE;
			step_count_q     <= '0;
			cnt_q            <= '0;
			acc_q            <= '0;
			sh_q             <= '0;
			addend_q         <= '0;
			rem_q            <= '0;
			mag_q            <= '0;
			sat_q            <= 1'b0;
			flat_q           <= 1'b0;
			out_valid_q      <= 1'b0;
			out_prop_q       <= '0;
			out_keep_q       <= 1'b0;
			out_best_x_q     <= '0;
			out_best_value_q <= '0;
			out_steps_q      <= '0;
		end else begin
			// response taken
			if (rsp.valid && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						unique case (req.operation)
							OP_SEED_PREV: begin
								before_x_q     <= req.point_x;
								before_slope_q <= req.objective_slope;
							end
							OP_SEED_CURR: begin
								here_x_q     <= req.point_x;
								here_value_q <= req.objective_value;
								here_slope_q <= req.objective_slope;
								heat_q       <= HEAT_ONE;
								step_count_q <= '0;
							end
							OP_EVAL: begin
								before_x_q     <= here_x_q;
								before_slope_q <= here_slope_q;
								here_x_q       <= pending_x_q;
								here_value_q   <= req.objective_value;
								here_slope_q   <= req.objective_slope;
								if (step_count_q != '1) begin
									step_count_q <= step_count_q + 1'b1;
								end
								// temperature product operands
								acc_q    <= '0;
								sat_q    <= 1'b0;
								addend_q <= PROD_W'(heat_q);
								sh_q     <= PROD_W'(temperature_factor_q) << (PROD_W - HW);
								cnt_q    <= ITER_W'(HW - 1);
							end
							default: ;
						endcase
					end
				end
				ST_HEAT: begin
					acc_q <= acc_next;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (last_iter) begin
						heat_q <= (h_sh > PROD_W'(HEAT_MAX)) ? HEAT_MAX : h_sh[HW-1:0];
					end
				end
				ST_SETUP: begin
					// heat * |dx|, iterating over the heat bits
					flat_q   <= (here_slope_q == before_slope_q);
					acc_q    <= '0;
					sat_q    <= 1'b0;
					addend_q <= PROD_W'(dx_mag);
					sh_q     <= PROD_W'(heat_q) << (PROD_W - HW);
					cnt_q    <= ITER_W'(HW - 1);
				end
				ST_MUL1: begin
					sat_q <= sat_q | mul_ovf;
					if (last_iter) begin
						// restoring division by |ddx|
						sh_q     <= prod1 << (PROD_W - DIV_N);
						rem_q    <= '0;
						acc_q    <= '0;
						addend_q <= PROD_W'(ddx_mag);
						cnt_q    <= ITER_W'(DIV_N - 1);
					end else begin
						acc_q <= acc_next;
						sh_q  <= sh_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? add_sum[W-1:0] : div_part[W-1:0];
					if (last_iter) begin
						// gamma * |slope|, iterating over the slope bits
						addend_q <= quot;
						acc_q    <= '0;
						sat_q    <= 1'b0;
						sh_q     <= PROD_W'(slope_mag) << (PROD_W - W);
						cnt_q    <= ITER_W'(W - 1);
					end else begin
						acc_q <= quot;
						sh_q  <= sh_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_MUL2: begin
					acc_q <= acc_next;
					sat_q <= sat_q | mul_ovf;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
				ST_CLAMP: begin
					// equal slopes move by the full step limit
					if (flat_q || (m_sh > PROD_W'(step_limit_q))) begin
						mag_q <= step_limit_q;
					end else begin
						mag_q <= m_sh[W-2:0];
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						pending_x_q      <= prop_x;
						out_valid_q      <= 1'b1;
						out_prop_q       <= prop_x;
						out_keep_q       <= slope_ok && heat_ok && max_ok && count_ok;
						out_best_x_q     <= here_x_q;
						out_best_value_q <= here_value_q;
						out_steps_q      <= step_count_q;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// seeding the previous point produces no work
	a_seed_prev_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation == OP_SEED_PREV) |=> state_q == ST_IDLE)
		else $error("seed of previous point left idle");

	// seeding the current point restarts heat and count
	a_seed_curr_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation == OP_SEED_CURR)
		|=> (step_count_q == '0 && heat_q == HEAT_ONE))
		else $error("seed of current point did not restart heat and count");

	// division never runs past its bit count
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < ITER_W'(DIV_N))
		else $error("division counter out of range");

	// the arithmetic path is never taken for equal slopes
	a_flat_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL1 || state_q == ST_DIV || state_q == ST_MUL2) |-> !flat_q)
		else $error("secant arithmetic with equal slopes");

	// leaving the final state always presents a result
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && state_d == ST_IDLE) |=> rsp.valid)
		else $error("final state left without a result");
`endif

endmodule

FILE: sim/annealed_secant_step_ascent_core_tb.sv
// self-checking bench for the annealed secant step ascent core: directed and random items
// over several register settings, with a built-in predictor and scoreboard
// depends on design/assa_pkg.sv, design/assa_if.sv and the core itself
module annealed_secant_step_ascent_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import assa_pkg::*;

	localparam int VW = 32;
	localparam int FB = 16;
	localparam int CW = 16;
	localparam longint VAL_HI = (64'sd1 <<< (VW - 1)) - 1;
	localparam longint VAL_LO = -VAL_HI - 1;
	localparam longint unsigned HEAT_ONE = 64'd1 << FB;
	localparam longint unsigned HEAT_MAX = (64'd1 << (FB + 1)) - 1;
	localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 1;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [VW-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VW-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [VW-1:0] Q_ONE = 32'sh0001_0000;
	localparam int QUIET_CYCLES = 160;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 80;

	typedef struct {
		logic signed [VW-1:0] proposed_x;
		logic                 keep_going;
		logic signed [VW-1:0] best_x;
		logic signed [VW-1:0] best_value;
		logic [CW-1:0]        steps_taken;
	} proposal_t;

	// mirror of the search state plus the queue of proposals still owed by the core
	class proposal_board;
		longint cur_x, prev_x, cur_slope, prev_slope, cur_value, queued_x;
		longint unsigned heat, steps;
		longint unsigned slope_tol, heat_floor, heat_factor, iter_limit, move_limit;
		longint target_max, max_margin;
		proposal_t due_proposals[$];
		int mismatches;
		int checked;

		function new();
			slope_tol = 655;
			heat_floor = 655;
			heat_factor = 32768;
			target_max = 0;
			max_margin = 0;
			iter_limit = 100;
			move_limit = 65536;
			cur_x = 0;
			prev_x = 0;
			cur_slope = 0;
			prev_slope = 0;
			cur_value = 0;
			queued_x = 0;
			heat = HEAT_ONE;
			steps = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VW-1:0] data);
			case (idx)
				REG_DERIV_TOL:   slope_tol = data[VW-2:0];
				REG_TEMP_FLOOR:  heat_floor = data[FB:0];
				REG_TEMP_FACTOR: heat_factor = data[FB:0];
				REG_TARGET_MAX:  target_max = $signed(data);
				REG_MAX_MARGIN:  max_margin = $signed(data);
				REG_ITER_LIMIT:  iter_limit = data[CW-1:0];
				REG_STEP_LIMIT:  move_limit = data[VW-2:0];
				default: ;
			endcase
		endfunction

		function longint unsigned span(longint a, longint b);
			return (a >= b) ? longint'(a - b) : longint'(b - a);
		endfunction

		function int sgn(longint v);
			return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
		endfunction

		// secant step: gain = heat*|dx|/|ddx|, move = gain*|slope| >> FB, clamped
		function longint propose_x();
			longint unsigned gain, move, mag;
			logic [127:0] wide;
			longint off, sum;
			if (cur_slope == prev_slope) begin
				off = longint'(move_limit);
			end else begin
				gain = (heat * span(cur_x, prev_x)) / span(cur_slope, prev_slope);
				mag = span(cur_slope, 0);
				wide = {64'd0, gain} * {64'd0, mag};
				if (wide[127:64] != 0)
					move = 64'hFFFF_FFFF_FFFF_FFFF >> FB;
				else
					move = wide[63:0] >> FB;
				if (move > move_limit)
					move = move_limit;
				off = (cur_slope < 0) ? -longint'(move) : longint'(move);
			end
			sum = cur_x + off;
			if (sum > VAL_HI)
				sum = VAL_HI;
			else if (sum < VAL_LO)
				sum = VAL_LO;
			return sum;
		endfunction

		function bit keep_going_now();
			return (span(cur_slope, 0) > slope_tol) && (heat > heat_floor) &&
				((target_max == max_margin) || (target_max - cur_value > max_margin)) &&
				(steps < iter_limit);
		endfunction

		// note one accepted input item and queue the proposal it causes, if any
		function void take_item(logic [OP_W-1:0] op, logic signed [VW-1:0] px,
			logic signed [VW-1:0] val, logic signed [VW-1:0] slope);
			proposal_t p;
			longint unsigned h;
			case (op)
				OP_SEED_PREV: begin
					prev_x = px;
					prev_slope = slope;
					return;
				end
				OP_SEED_CURR: begin
					cur_x = px;
					cur_value = val;
					cur_slope = slope;
					heat = HEAT_ONE;
					steps = 0;
				end
				OP_EVAL: begin
					prev_x = cur_x;
					prev_slope = cur_slope;
					cur_x = queued_x;
					cur_value = val;
					cur_slope = slope;
					// anneal on a change of slope sign
					if (sgn(prev_slope) != sgn(cur_slope)) begin
						h = (heat * heat_factor) >> FB;
						heat = (h > HEAT_MAX) ? HEAT_MAX : h;
					end
					if (steps < COUNT_MAX)
						steps++;
				end
				default: return;
			endcase
			queued_x = propose_x();
			p.proposed_x = queued_x[VW-1:0];
			p.keep_going = keep_going_now();
			p.best_x = cur_x[VW-1:0];
			p.best_value = cur_value[VW-1:0];
			p.steps_taken = steps[CW-1:0];
			due_proposals.push_back(p);
		endfunction

		function void check_proposal(proposal_t got);
			proposal_t want;
			checked++;
			if (due_proposals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: proposal x=%0d with none outstanding", $time, got.proposed_x);
				return;
			end
			want = due_proposals.pop_front();
			if (got.proposed_x !== want.proposed_x || got.keep_going !== want.keep_going ||
				got.best_x !== want.best_x || got.best_value !== want.best_value ||
				got.steps_taken !== want.steps_taken) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: proposal %0d expected/actual: x %0d/%0d keep %0b/%0b",
						$time, checked, want.proposed_x, got.proposed_x,
						want.keep_going, got.keep_going);
					$display("    best_x %0d/%0d value %0d/%0d steps %0d/%0d",
						want.best_x, got.best_x, want.best_value, got.best_value,
						want.steps_taken, got.steps_taken);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int sender_idle = 31;
	int receiver_idle = 61;
	int accepted = 0;
	int ignored = 0;
	int settings = 0;
	int cycles = 0;
	proposal_board board;

	assa_req_if #(.VALUE_WIDTH(VW)) req_ch ();
	assa_rsp_if #(.VALUE_WIDTH(VW), .COUNT_WIDTH(CW)) rsp_ch ();
	assa_cfg_if #(.VALUE_WIDTH(VW)) cfg_ch ();

	annealed_secant_step_ascent_core #(
		.VALUE_WIDTH(VW),
		.FRACTION_BITS(FB),
		.COUNT_WIDTH(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("run stopped by the cycle limit with %0d proposals outstanding",
			board.due_proposals.size());
		$display("Verification failed");
		$finish;
	end

	// result side: check each accepted item, then stall at random
	initial begin
		proposal_t got;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.proposed_x = rsp_ch.proposed_x;
				got.keep_going = rsp_ch.keep_going;
				got.best_x = rsp_ch.best_x;
				got.best_value = rsp_ch.best_value;
				got.steps_taken = rsp_ch.steps_taken;
				board.check_proposal(got);
			end
			rsp_ch.ready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	function automatic logic signed [VW-1:0] sat32(longint v);
		if (v > VAL_HI)
			return Q_MAX;
		if (v < VAL_LO)
			return Q_MIN;
		return v[VW-1:0];
	endfunction

	// mostly small Q16.16 values, some medium, some raw, some range ends
	function automatic logic signed [VW-1:0] rand_q();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: v = int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
			5, 6, 7: v = int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
			8: v = $urandom;
			default: begin
				case ($urandom_range(4))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
		endcase
		return v;
	endfunction

	// host objective: a downward parabola around peak_x
	function automatic void host_eval(input longint x, input longint peak_x, input longint peak_v,
		input int bend, output logic signed [VW-1:0] slope, output logic signed [VW-1:0] value);
		longint d;
		d = peak_x - x;
		slope = sat32(d >>> bend);
		if (d > (64'sd1 <<< 31))
			d = 64'sd1 <<< 31;
		else if (d < -(64'sd1 <<< 31))
			d = -(64'sd1 <<< 31);
		value = sat32(peak_v - ((d * d) >>> (FB + 1 + bend)));
	endfunction

	// present one item, wait for its acceptance, then note it
	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VW-1:0] px,
		input logic signed [VW-1:0] val, input logic signed [VW-1:0] slope);
		while ($urandom_range(99) < sender_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.point_x <= px;
		req_ch.objective_value <= val;
		req_ch.objective_slope <= slope;
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.take_item(op, px, val, slope);
		if (op == OP_UNUSED)
			ignored++;
		else
			accepted++;
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [VW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		board.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [VW-1:0] tol, input logic [VW-1:0] floor_v,
		input logic [VW-1:0] factor, input logic [VW-1:0] tgt, input logic [VW-1:0] margin,
		input logic [VW-1:0] iters, input logic [VW-1:0] step);
		set_reg(REG_DERIV_TOL, tol);
		set_reg(REG_TEMP_FLOOR, floor_v);
		set_reg(REG_TEMP_FACTOR, factor);
		set_reg(REG_TARGET_MAX, tgt);
		set_reg(REG_MAX_MARGIN, margin);
		set_reg(REG_ITER_LIMIT, iters);
		set_reg(REG_STEP_LIMIT, step);
		settings++;
	endtask

	task automatic apply_random_setting();
		logic signed [VW-1:0] tgt;
		tgt = rand_q();
		apply_setting($urandom_range(32'h0010_0000), $urandom_range(2000),
			$urandom_range(32'h0001_0000), tgt,
			($urandom_range(3) == 0) ? tgt : $urandom_range(32'h0010_0000),
			$urandom_range(64), $urandom_range(32'h0040_0000));
	endtask

	// drop valid, let every proposal come back, then let the core go quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (board.due_proposals.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// searches: two seeds then a run of evaluations at the proposed x, with some noise
	task automatic run_phase(input int n);
		int sent, len, bend;
		longint peak_x, peak_v, x;
		logic [OP_W-1:0] code;
		logic signed [VW-1:0] slope, value;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 10) begin
				code = OP_W'($urandom_range(3));
				send_item(code, $urandom, $urandom, $urandom);
				if (code != OP_UNUSED)
					sent++;
			end else begin
				peak_x = rand_q();
				peak_v = rand_q();
				bend = $urandom_range(4);
				len = $urandom_range(2, 14);
				x = sat32(peak_x + rand_q());
				host_eval(x, peak_x, peak_v, bend, slope, value);
				send_item(OP_SEED_PREV, x, value, slope);
				// occasionally both seeds at the same x
				if ($urandom_range(9) != 0)
					x = sat32(x + (rand_q() >>> $urandom_range(4)));
				host_eval(x, peak_x, peak_v, bend, slope, value);
				send_item(OP_SEED_CURR, x, value, slope);
				sent += 2;
				repeat (len) begin
					host_eval(board.queued_x, peak_x, peak_v, bend, slope, value);
					case ($urandom_range(19))
						0, 1: slope = rand_q();
						2: slope = board.cur_slope[VW-1:0];
						default: ;
					endcase
					send_item(OP_EVAL, rand_q(), value, slope);
					sent++;
				end
			end
		end
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_SEED_PREV;
		req_ch.point_x <= '0;
		req_ch.objective_value <= '0;
		req_ch.objective_slope <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_DERIV_TOL;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// evaluation straight after reset, before any seed
		send_item(OP_EVAL, Q_MAX, Q_ONE, Q_ONE);
		// seeds with equal slopes: the move is the full step limit
		send_item(OP_SEED_PREV, 0, 0, 0);
		send_item(OP_SEED_CURR, 0, 0, 0);
		// slope extremes, sign flips and zero slopes
		send_item(OP_EVAL, Q_MIN, Q_MAX, Q_MAX);
		send_item(OP_EVAL, Q_MAX, Q_MIN, Q_MIN);
		send_item(OP_EVAL, 0, 0, 0);
		send_item(OP_EVAL, 0, -1, 0);
		// slopes around the default tolerance
		send_item(OP_EVAL, 0, 1, 655);
		send_item(OP_EVAL, 0, 1, 656);
		send_item(OP_EVAL, 0, 1, -656);
		// unused code with every field bit set
		send_item(OP_UNUSED, -1, -1, -1);
		// seeds at the range ends: products saturate
		send_item(OP_SEED_PREV, Q_MIN, 0, Q_MAX);
		send_item(OP_SEED_CURR, Q_MAX, Q_MAX, Q_MIN);
		send_item(OP_EVAL, 0, Q_MIN, 1);
		send_item(OP_EVAL, 0, 0, -1);
		// proposed x saturates at the top
		send_item(OP_SEED_PREV, Q_MAX, 0, 0);
		send_item(OP_SEED_CURR, Q_MAX, 0, 0);
		send_item(OP_EVAL, 0, -1, Q_MAX);
		// both seeds at one x: zero secant gain
		send_item(OP_SEED_PREV, Q_MIN, 0, 5);
		send_item(OP_SEED_CURR, Q_MIN, 0, -5);
		send_item(OP_EVAL, 0, 0, -Q_ONE);

		// sender idles less than receiver
		settle();
		apply_setting(32'h0000_0100, 32'd100, 32'h0000_C000, 32'h0005_0000, 32'h0001_0000,
			32'd40, 32'h0004_0000);
		run_phase(PHASE_ITEMS);
		settle();
		apply_setting(32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, Q_MAX, Q_MIN,
			32'h0000_FFFF, 32'h7FFF_FFFF);
		run_phase(PHASE_ITEMS);

		// receiver idles less than sender
		settle();
		sender_idle = 61;
		receiver_idle = 31;
		apply_setting(0, 0, 0, Q_MIN, Q_MIN, 0, 0);
		run_phase(PHASE_ITEMS);
		settle();
		apply_random_setting();
		run_phase(PHASE_ITEMS);

		// no idling on either side
		settle();
		sender_idle = 0;
		receiver_idle = 0;
		apply_setting(32'h0000_0800, 32'd3000, 32'h0000_F000, -32'sh0002_0000, 32'h0000_8000,
			32'd12, 32'h0010_0000);
		run_phase(PHASE_ITEMS);
		settle();
		apply_random_setting();
		run_phase(PHASE_ITEMS);
		settle();

		$display("run covered %0d items (%0d with the unused code), %0d proposals checked",
			accepted + ignored, ignored, board.checked);
		$display("over %0d register settings besides the reset one; %0d mismatches",
			settings, board.mismatches);
		if (board.mismatches == 0 && board.due_proposals.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
